@@ rtl/core/tfwm_pkg.sv @@
// Shared types and constants for the topic filter wildcard matcher.
package tfwm_pkg;

    localparam int MAX_FILTER_LEN_DEF = 256;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_NAME   = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] char_code;
        logic       no_byte;
        logic       last;
    } item_t;

    typedef struct packed {
        logic matched;
        logic filter_overflow;
    } result_t;

    // Decoded item as it travels from the front to the back.
    typedef struct packed {
        logic       is_name;
        logic       has_byte;
        logic       last;
        logic [7:0] char_code;
    } op_t;

endpackage

@@ rtl/core/tfwm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module tfwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/tfwm_front.sv @@
// Front end: accepts items, decodes them and queues them for the back end.
module tfwm_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  tfwm_pkg::item_t item,
    output logic            op_valid,
    output tfwm_pkg::op_t   op,
    input  logic            op_take
);

    localparam int PW = (tfwm_pkg::QUEUE_DEPTH > 1) ? $clog2(tfwm_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(tfwm_pkg::QUEUE_DEPTH + 1);

    tfwm_pkg::op_t   q_reg [tfwm_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg;
    logic [PW-1:0]   wptr_next;
    logic [PW-1:0]   rptr_reg;
    logic [PW-1:0]   rptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;
    tfwm_pkg::op_t   dec;

    assign full     = (count_reg == CW'(tfwm_pkg::QUEUE_DEPTH));
    assign op_valid = (count_reg != '0);
    assign op       = q_reg[rptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = op_take && op_valid;

    always_comb
    begin
        dec.is_name   = (item.command == tfwm_pkg::CMD_NAME);
        dec.has_byte  = !item.no_byte;
        dec.last      = item.last;
        dec.char_code = item.char_code;
    end

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PW'(tfwm_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PW'(tfwm_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wptr_reg] <= dec;
        end
    end

endmodule

@@ rtl/core/tfwm_back.sv @@
// Back end: filter store, match sequencer and result register.
module tfwm_back #(
    parameter int MAX_FILTER_LEN = tfwm_pkg::MAX_FILTER_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              op_valid,
    input  tfwm_pkg::op_t     op,
    output logic              op_take,
    output logic              res_valid,
    output tfwm_pkg::result_t res,
    input  logic              res_pop
);

    localparam int LW = $clog2(MAX_FILTER_LEN + 1);
    localparam int AW = $clog2(MAX_FILTER_LEN);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOOK = 7'b0000010,
        S_DATA = 7'b0000100,
        S_FIN  = 7'b0001000,
        S_FIN0 = 7'b0010000,
        S_FIN1 = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    tfwm_pkg::op_t     cur_reg;
    tfwm_pkg::op_t     cur_next;
    logic [LW-1:0]     len_reg;
    logic [LW-1:0]     len_next;
    logic [LW-1:0]     pos_reg;
    logic [LW-1:0]     pos_next;
    logic              skip_reg;
    logic              skip_next;
    logic              decided_reg;
    logic              decided_next;
    logic              verdict_reg;
    logic              verdict_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              open_reg;
    logic              open_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    tfwm_pkg::result_t out_reg;
    tfwm_pkg::result_t out_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [7:0]        ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [7:0]        ram_rdata;

    logic [LW-1:0]     pos_inc;
    logic              pos_end;
    logic              out_free;

    tfwm_ram #(
        .WIDTH (8),
        .DEPTH (MAX_FILTER_LEN)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pos_inc   = pos_reg + 1'b1;
    assign pos_end   = (pos_reg >= len_reg);
    assign out_free  = !out_valid_reg || res_pop;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        logic [LW-1:0] base_len;
        logic          consume_done;

        base_len       = open_reg ? len_reg : '0;
        consume_done   = 1'b0;
        state_next     = state_reg;
        cur_next       = cur_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        skip_next      = skip_reg;
        decided_next   = decided_reg;
        verdict_next   = verdict_reg;
        ovf_next       = ovf_reg;
        open_next      = open_reg;
        out_valid_next = out_valid_reg && !res_pop;
        out_next       = out_reg;
        op_take        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = base_len[AW-1:0];
        ram_wdata      = op.char_code;
        ram_raddr      = pos_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (op_valid)
                begin
                    op_take = 1'b1;
                    if (!op.is_name)
                    begin
                        pos_next     = '0;
                        skip_next    = 1'b0;
                        decided_next = 1'b0;
                        verdict_next = 1'b0;
                        len_next     = base_len;
                        if (!open_reg)
                        begin
                            ovf_next = 1'b0;
                        end
                        if (op.has_byte)
                        begin
                            if (base_len < LW'(MAX_FILTER_LEN))
                            begin
                                ram_we   = 1'b1;
                                len_next = base_len + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        open_next = !op.last;
                    end
                    else
                    begin
                        cur_next  = op;
                        open_next = 1'b0;
                        if (op.has_byte && !decided_reg)
                        begin
                            state_next = S_LOOK;
                        end
                        else if (op.last)
                        begin
                            state_next = decided_reg ? S_EMIT : S_FIN;
                        end
                    end
                end
            end
            S_LOOK:
            begin
                if (skip_reg && (cur_reg.char_code != tfwm_pkg::CH_SLASH))
                begin
                    consume_done = 1'b1;
                end
                else
                begin
                    skip_next = 1'b0;
                    if (pos_end)
                    begin
                        decided_next = 1'b1;
                        verdict_next = 1'b0;
                        consume_done = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DATA;
                    end
                end
            end
            S_DATA:
            begin
                if (ram_rdata == tfwm_pkg::CH_HASH)
                begin
                    decided_next = 1'b1;
                    verdict_next = 1'b1;
                    consume_done = 1'b1;
                end
                else if (ram_rdata == tfwm_pkg::CH_PLUS)
                begin
                    pos_next   = pos_inc;
                    skip_next  = 1'b1;
                    state_next = S_LOOK;
                end
                else if (ram_rdata == cur_reg.char_code)
                begin
                    pos_next     = pos_inc;
                    consume_done = 1'b1;
                end
                else
                begin
                    decided_next = 1'b1;
                    verdict_next = 1'b0;
                    consume_done = 1'b1;
                end
            end
            S_FIN:
            begin
                if (pos_end)
                begin
                    decided_next = 1'b1;
                    verdict_next = 1'b1;
                    state_next   = S_EMIT;
                end
                else
                begin
                    state_next = S_FIN0;
                end
            end
            S_FIN0:
            begin
                ram_raddr = pos_inc[AW-1:0];
                if ((ram_rdata != tfwm_pkg::CH_SLASH) || (pos_inc >= len_reg))
                begin
                    decided_next = 1'b1;
                    verdict_next = 1'b0;
                    state_next   = S_EMIT;
                end
                else
                begin
                    state_next = S_FIN1;
                end
            end
            S_FIN1:
            begin
                decided_next = 1'b1;
                verdict_next = (ram_rdata == tfwm_pkg::CH_HASH);
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next.matched         = verdict_reg;
                    out_next.filter_overflow = ovf_reg;
                    out_valid_next           = 1'b1;
                    pos_next                 = '0;
                    skip_next                = 1'b0;
                    decided_next             = 1'b0;
                    verdict_next             = 1'b0;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (consume_done)
        begin
            if (cur_reg.last)
            begin
                state_next = decided_next ? S_EMIT : S_FIN;
            end
            else
            begin
                state_next = S_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            pos_reg       <= '0;
            skip_reg      <= 1'b0;
            decided_reg   <= 1'b0;
            verdict_reg   <= 1'b0;
            ovf_reg       <= 1'b0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            pos_reg       <= pos_next;
            skip_reg      <= skip_next;
            decided_reg   <= decided_next;
            verdict_reg   <= verdict_next;
            ovf_reg       <= ovf_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule

@@ rtl/core/topic_filter_wildcard_match_core.sv @@
// Top level of the topic filter wildcard matcher.
//
// Input queue: item (command, char_code, no_byte, last) is taken on a clock
// edge with push high and full low. Filter items (command 0) load the filter
// store one byte each; name items (command 1) are matched against it.
// Result queue: while empty is low, result holds the verdict for the latest
// completed name (matched, filter_overflow); it is taken with pop high.
// Exactly one result comes from each name item with last set.
// A two-entry input queue sits ahead of the match sequencer, so items are
// taken while a result waits to be popped.
// Steps per item in the sequencer: a filter item is handled in the idle
// state. A name byte passes through idle, look and data for a plain compare,
// and through look and data once more per '+' crossed by a '/'; a byte
// skipped under a '+' or past the end of the filter passes through idle and
// look, and one after the verdict is known through idle alone. The last name
// item adds end-of-filter checks (fin, then fin0 and fin1 as needed) and an
// emit step to post the result. The filter store is a single read port RAM
// with registered read data, so a filter entry is read in look, used in data.
// Reset clears the queues, filter length, match state and overflow flag;
// store contents are not cleared. A stalled result queue holds the sequencer
// at its final step while the input queue keeps filling up to full.
module topic_filter_wildcard_match_core #(
    parameter int MAX_FILTER_LEN = tfwm_pkg::MAX_FILTER_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  tfwm_pkg::item_t   item,
    output logic              empty,
    input  logic              pop,
    output tfwm_pkg::result_t result
);

    logic          op_valid;
    logic          op_take;
    tfwm_pkg::op_t op;
    logic          res_valid;

    tfwm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take)
    );

    tfwm_back #(
        .MAX_FILTER_LEN (MAX_FILTER_LEN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (op_valid),
        .op        (op),
        .op_take   (op_take),
        .res_valid (res_valid),
        .res       (result),
        .res_pop   (pop)
    );

    assign empty = !res_valid;

endmodule

@@ rtl/core/tfwm_checker.sv @@
// Port-level assertions for the topic filter wildcard matcher, bound to the top.
module tfwm_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input tfwm_pkg::result_t result
);

    a_reset_state: assert property (@(posedge clk)
        $past(!rst_n) && rst_n |-> !full && empty)
        else $error("queues not empty after reset");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or dropped");

    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("input queue filled without a push");

    a_empty_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(empty) |-> $past(pop))
        else $error("result vanished without a pop");

endmodule

bind topic_filter_wildcard_match_core tfwm_checker u_tfwm_checker (.*);
